@@ design/erfe_pkg.sv @@
// Shared types and constants for the error flag register with events.
`timescale 1ns / 1ps

package erfe_pkg;

  localparam int VEC_W = 64;  // width of code, mask and flags_now ports
  localparam int IDX_W = 6;   // bit_index width
  localparam int CNT_W = 7;   // change_count width

  // command modes
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_MCLR   = 2'd1,
    MODE_CLRALL = 2'd2,
    MODE_UCLR   = 2'd3
  } mode_t;

  // result event kinds
  typedef enum logic [1:0] {
    EV_RAISE = 2'd0,
    EV_CLEAR = 2'd1,
    EV_NOCHG = 2'd2
  } ev_kind_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // status of the bit under the scan unit
  typedef struct packed {
    logic hit;      // current bit changed
    logic set;      // current bit is set in the new vector
    logic is_last;  // no changed bits above the current one
    logic empty;    // no changed bits left at all
  } scan_stat_t;

endpackage

@@ design/erfe_scan.sv @@
// Bit scan unit: shift registers that walk the changed-bit vector one bit a cycle while step is high.
`timescale 1ns / 1ps

module erfe_scan #(
  parameter int FLAG_BITS = 64
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [FLAG_BITS-1:0]        changed,
  input  logic [FLAG_BITS-1:0]        next_flags,
  output erfe_pkg::scan_stat_t        stat,
  output logic [erfe_pkg::IDX_W-1:0]  index
);

  logic [FLAG_BITS-1:0] chg_sr;
  logic [FLAG_BITS-1:0] nxt_sr;

  // load on command accept, shift right on each step
  always_ff @(posedge clk) begin
    if (load) begin
      chg_sr <= changed;
      nxt_sr <= next_flags;
      index  <= '0;
    end else if (step) begin
      chg_sr <= chg_sr >> 1;
      nxt_sr <= nxt_sr >> 1;
      index  <= index + 1'b1;
    end
  end

  // status of the bit at the bottom of the shifter
  always_comb begin
    stat.hit     = chg_sr[0];
    stat.set     = nxt_sr[0];
    stat.is_last = ((chg_sr >> 1) == '0);
    stat.empty   = (chg_sr == '0);
  end

endmodule

@@ design/error_flag_register_with_events_core.sv @@
// Top level: flag register, mask register, scan sequencer and result register.
// The scan shifter walks one bit per cycle, but holds on a changed bit while the output is stalled.
// A command is taken only in idle, so a new one waits until the previous scan is done.
// in_stall is high while a command is scanned.
// Reset (rst, synchronous): flags and mask clear to zero, sequencer idle, no result pending.
`timescale 1ns / 1ps

module error_flag_register_with_events_core #(
  parameter int FLAG_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [erfe_pkg::VEC_W-1:0]            cfg_data,
  // command input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            mode,
  input  logic [erfe_pkg::VEC_W-1:0]            code,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            event_kind,
  output logic [erfe_pkg::IDX_W-1:0]            bit_index,
  output logic [erfe_pkg::CNT_W-1:0]            change_count,
  output logic [erfe_pkg::VEC_W-1:0]            flags_now,
  output logic                                  last
);

  erfe_pkg::state_t             state, state_next;
  logic [FLAG_BITS-1:0]         flags;
  logic [FLAG_BITS-1:0]         error_mask;
  logic [FLAG_BITS-1:0]         code_v;
  logic [FLAG_BITS-1:0]         flags_next;
  logic [FLAG_BITS-1:0]         changed;
  logic [erfe_pkg::CNT_W-1:0]   count;
  logic [erfe_pkg::CNT_W-1:0]   count_inc;
  erfe_pkg::scan_stat_t         stat;
  logic [erfe_pkg::IDX_W-1:0]   scan_idx;
  logic                         in_accept;
  logic                         out_free;
  logic                         scan_step;
  logic                         emit_event;
  logic                         emit_nochg;
  logic                         done;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign code_v    = code[FLAG_BITS-1:0];
  assign count_inc = count + 1'b1;

  // new flag vector for the command
  always_comb begin
    case (erfe_pkg::mode_t'(mode))
      erfe_pkg::MODE_LOAD:   flags_next = code_v;
      erfe_pkg::MODE_MCLR:   flags_next = flags & ~(code_v & ~error_mask);
      erfe_pkg::MODE_CLRALL: flags_next = flags & error_mask;
      default:               flags_next = flags & ~code_v;
    endcase
  end
  assign changed = flags ^ flags_next;

  // flag and mask registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      error_mask <= '0;
    end else begin
      if (cfg_valid && cfg_ready) error_mask <= cfg_data[FLAG_BITS-1:0];
      if (in_accept)              flags      <= flags_next;
    end
  end

  erfe_scan #(.FLAG_BITS(FLAG_BITS)) u_scan (
    .clk        (clk),
    .load       (in_accept),
    .step       (scan_step),
    .changed    (changed),
    .next_flags (flags_next),
    .stat       (stat),
    .index      (scan_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      erfe_pkg::ST_IDLE: if (in_accept) state_next = erfe_pkg::ST_SCAN;
      erfe_pkg::ST_SCAN: if (done) state_next = erfe_pkg::ST_IDLE;
      default:           state_next = erfe_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    scan_step  = 1'b0;
    emit_event = 1'b0;
    emit_nochg = 1'b0;
    done       = 1'b0;
    case (state)
      erfe_pkg::ST_IDLE: in_stall = 1'b0;
      erfe_pkg::ST_SCAN: begin
        if (stat.empty) begin
          // nothing changed: one no-change result
          emit_nochg = out_free;
          done       = out_free;
        end else if (stat.hit) begin
          emit_event = out_free;
          scan_step  = out_free;
          done       = out_free && stat.is_last;
        end else begin
          scan_step  = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= erfe_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // events emitted so far for this command
  always_ff @(posedge clk) begin
    if (rst || in_accept) count <= '0;
    else if (emit_event)  count <= count_inc;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_event || emit_nochg) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_nochg) begin
      event_kind   <= erfe_pkg::EV_NOCHG;
      bit_index    <= '0;
      change_count <= '0;
      flags_now    <= erfe_pkg::VEC_W'(flags);
      last         <= 1'b1;
    end else if (emit_event) begin
      event_kind   <= stat.set ? erfe_pkg::EV_RAISE : erfe_pkg::EV_CLEAR;
      bit_index    <= scan_idx;
      change_count <= stat.is_last ? count_inc : '0;
      flags_now    <= stat.is_last ? erfe_pkg::VEC_W'(flags) : '0;
      last         <= stat.is_last;
    end
  end

endmodule

@@ design/erfe_checker.sv @@
// Port-level assertions for the error flag register core, with bind.
`timescale 1ns / 1ps

module erfe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [erfe_pkg::VEC_W-1:0]   cfg_data,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   mode,
  input logic [erfe_pkg::VEC_W-1:0]   code,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   event_kind,
  input logic [erfe_pkg::IDX_W-1:0]   bit_index,
  input logic [erfe_pkg::CNT_W-1:0]   change_count,
  input logic [erfe_pkg::VEC_W-1:0]   flags_now,
  input logic                         last
);

  // a stalled beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // block is busy the cycle after taking a command
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while previous still scanning");

  // non-final beats carry no count or vector
  a_mid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> change_count == '0 && flags_now == '0
      && event_kind != erfe_pkg::EV_NOCHG)
    else $error("non-final beat carries summary fields");

  // no-change beat is a lone final beat
  a_nochg: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == erfe_pkg::EV_NOCHG |->
      last && bit_index == '0 && change_count == '0)
    else $error("malformed no-change beat");

  // a final event beat reports at least one change
  a_last_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && event_kind != erfe_pkg::EV_NOCHG |-> change_count != '0)
    else $error("final event beat with zero count");

endmodule

bind error_flag_register_with_events_core erfe_checker u_erfe_checker (.*);

@@ test/tb_error_flag_register_with_events_core.sv @@
// Testbench for the error flag register: directed and random commands, self-checking events.
`timescale 1ns / 1ps

module tb_error_flag_register_with_events_core;
  import erfe_pkg::*;

  localparam int FLAG_BITS = 64;
  localparam int LIMIT     = 400000;  // watchdog, in clock cycles
  localparam int HOLD_LEN  = 300;     // long receiver hold-off, in cycles
  localparam int PHASE_N   = 36;      // commands per random phase

  // one expected output beat
  typedef struct {
    ev_kind_t           kind;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic [VEC_W-1:0]   flags;
    logic               fin;
  } flag_event_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [VEC_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_LOAD;
  logic [VEC_W-1:0]   code = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         event_kind;
  logic [IDX_W-1:0]   bit_index;
  logic [CNT_W-1:0]   change_count;
  logic [VEC_W-1:0]   flags_now;
  logic               last;

  // predictor state
  logic [VEC_W-1:0]   flags_model = '0;
  logic [VEC_W-1:0]   mask_model = '0;
  flag_event_t        pending_events[$];

  int                 err_count = 0;
  int                 cycle_count = 0;
  int                 in_pct = 0;
  int                 out_pct = 0;
  int                 hold_req = 0;

  error_flag_register_with_events_core #(
    .FLAG_BITS(FLAG_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .code(code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_kind(event_kind),
    .bit_index(bit_index),
    .change_count(change_count),
    .flags_now(flags_now),
    .last(last)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT) begin
        $display("tb_error_flag_register_with_events_core: errors");
        $finish;
      end
    end
  end

  // apply one command to the flag model and queue the events it causes
  function automatic void predict_flag_events(input mode_t m, input logic [VEC_W-1:0] c);
    logic [VEC_W-1:0] valid_bits;
    logic [VEC_W-1:0] cur;
    logic [VEC_W-1:0] nxt;
    logic [VEC_W-1:0] changed;
    int               total;
    int               seen;
    flag_event_t      ev;
    valid_bits = {VEC_W{1'b1}} >> (VEC_W - FLAG_BITS);
    cur = flags_model & valid_bits;
    case (m)
      MODE_LOAD:   nxt = c & valid_bits;
      MODE_MCLR:   nxt = cur & ~(c & valid_bits & ~mask_model);
      MODE_CLRALL: nxt = cur & mask_model;
      default:     nxt = cur & ~(c & valid_bits);
    endcase
    nxt &= valid_bits;
    changed = cur ^ nxt;
    flags_model = nxt;
    total = $countones(changed);
    if (total == 0) begin
      ev = '{EV_NOCHG, '0, '0, nxt, 1'b1};
      pending_events.push_back(ev);
    end else begin
      seen = 0;
      for (int i = 0; i < VEC_W; i++) begin
        if (changed[i]) begin
          seen++;
          ev.kind = nxt[i] ? EV_RAISE : EV_CLEAR;
          ev.idx  = IDX_W'(i);
          // count and vector only on the closing beat
          ev.cnt   = (seen == total) ? CNT_W'(total) : '0;
          ev.flags = (seen == total) ? nxt : '0;
          ev.fin   = (seen == total);
          pending_events.push_back(ev);
        end
      end
    end
  endfunction

  // output stall driver, with an on-demand long hold-off
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    flag_event_t ev;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat kind=%0d idx=%0d cnt=%0d flags=%h last=%b",
                 $time, event_kind, bit_index, change_count, flags_now, last);
      end else begin
        ev = pending_events.pop_front();
        if (event_kind !== ev.kind || bit_index !== ev.idx || change_count !== ev.cnt ||
            flags_now !== ev.flags || last !== ev.fin) begin
          err_count++;
          $display("%0t: mismatch expected kind=%0d idx=%0d cnt=%0d flags=%h last=%b",
                   $time, ev.kind, ev.idx, ev.cnt, ev.flags, ev.fin);
          $display("%0t:          actual   kind=%0d idx=%0d cnt=%0d flags=%h last=%b",
                   $time, event_kind, bit_index, change_count, flags_now, last);
        end
      end
    end
  end

  // offer one command, with a random idle gap ahead of it, and wait until it is taken
  task automatic send_command(input mode_t m, input logic [VEC_W-1:0] c);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < in_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    code     <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_flag_events(m, c);
  endtask

  // stop offering and let every queued event come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the mask register while the block is idle
  task automatic write_mask(input logic [VEC_W-1:0] v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    mask_model = v;
  endtask

  // full-vector loads: all raised, no change, all cleared, edge bits
  task automatic test_load_extremes();
    write_mask('0);
    send_command(MODE_LOAD, '1);
    send_command(MODE_LOAD, '1);
    send_command(MODE_LOAD, '0);
    send_command(MODE_LOAD, 64'h8000_0000_0000_0000);
    send_command(MODE_LOAD, 64'h0000_0000_0000_0001);
    send_command(MODE_LOAD, '0);
  endtask

  // mode 1 honors the mask
  task automatic test_masked_clear();
    write_mask(64'h00FF_00FF_00FF_00FF);
    send_command(MODE_LOAD, '1);
    send_command(MODE_MCLR, '1);
    send_command(MODE_MCLR, '1);
    write_mask('1);
    send_command(MODE_LOAD, {$urandom, $urandom});
    send_command(MODE_MCLR, '1);
  endtask

  // mode 2 ignores code and clears every unprotected flag
  task automatic test_clear_all();
    write_mask('0);
    send_command(MODE_LOAD, '1);
    send_command(MODE_CLRALL, {$urandom, $urandom});
    send_command(MODE_CLRALL, '1);
    write_mask({$urandom, $urandom});
    send_command(MODE_LOAD, '1);
    send_command(MODE_CLRALL, '0);
  endtask

  // mode 3 clears regardless of the mask
  task automatic test_unmasked_clear();
    write_mask('1);
    send_command(MODE_LOAD, '1);
    send_command(MODE_UCLR, 64'h8000_0000_0000_0001);
    send_command(MODE_UCLR, '1);
    send_command(MODE_UCLR, '0);
  endtask

  // receiver holds off for a long stretch while full swings keep coming
  task automatic test_backpressure();
    write_mask('0);
    in_pct  = 0;
    out_pct = 0;
    hold_req++;
    for (int i = 0; i < 8; i++) begin
      send_command(MODE_LOAD, i[0] ? {VEC_W{1'b0}} : {VEC_W{1'b1}});
    end
  endtask

  // random commands under one idling setting
  task automatic test_random_phase(input int ipct, input int opct,
                                   input logic [VEC_W-1:0] mask_val);
    mode_t            m;
    logic [VEC_W-1:0] c;
    int               pick;
    write_mask(mask_val);
    in_pct  = ipct;
    out_pct = opct;
    for (int n = 0; n < PHASE_N; n++) begin
      // loads are weighted up so the clears have flags to work on
      pick = $urandom_range(9);
      m = (pick < 4) ? MODE_LOAD : mode_t'($urandom_range(3));
      case ($urandom_range(3))
        0: c = {$urandom, $urandom};
        1: c = 64'd1 << $urandom_range(63);
        2: c = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        default: c = ~({$urandom, $urandom} & {$urandom, $urandom});
      endcase
      send_command(m, c);
    end
  endtask

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_extremes();
    test_masked_clear();
    test_clear_all();
    test_unmasked_clear();
    test_backpressure();
    test_random_phase(0, 0, {$urandom, $urandom});
    test_random_phase(51, 0, '0);
    test_random_phase(0, 51, '1);
    test_random_phase(12, 12, {$urandom, $urandom} & {$urandom, $urandom});
    wait_drain();
    repeat (FLAG_BITS + 8) @(posedge clk);
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("tb_error_flag_register_with_events_core: clean");
    end else begin
      $display("tb_error_flag_register_with_events_core: errors");
    end
    $finish;
  end

endmodule
